### sv/text_image_orientation_engine_defines.svh
// Assertion macros shared by the queue and back-end modules of the orientation engine.
`ifndef TEXT_IMAGE_ORIENTATION_ENGINE_DEFINES_SVH
`define TEXT_IMAGE_ORIENTATION_ENGINE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define TIOE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define TIOE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TIOE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tioe_pkg.sv
`default_nettype none

package tioe_pkg;

  localparam logic [1:0] ACT_STORE = 2'd0;
  localparam logic [1:0] ACT_EOL   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_FETCH = 2'd3;

  localparam logic [2:0] MODE_ORIGINAL  = 3'd0;
  localparam logic [2:0] MODE_INVERTED  = 3'd1;
  localparam logic [2:0] MODE_VFLIP     = 3'd2;
  localparam logic [2:0] MODE_HFLIP     = 3'd3;
  localparam logic [2:0] MODE_ROTATE    = 3'd4;
  localparam logic [2:0] MODE_TRANSPOSE = 3'd5;

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_AT    = 8'd64;

  localparam int IDX_W       = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [1:0] {
    OP_WRITE_CHAR,
    OP_WRITE_LEN,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [7:0]       data;
    logic             row_end;
    logic             image_end;
    logic             empty;
    logic             invert;
  } cmd_t;

endpackage

`default_nettype wire

### sv/text_image_orientation_engine.sv
// Channel  Handshake         Word
// in       in_valid/stall    in_action, in_char_code
// out      out_valid/stall   out_char, out_row_end, out_image_end, out_picture_empty
// cfg      cfg_valid/ready   cfg_orientation_mode
//
// The front takes one word per cycle while its four-entry command queue has room.
// A fetch passes the command queue, the memory read register, then the map into the result register.
// Sustained rate is one word per cycle while out_stall is low, set by the single port of the character memory.
// Synchronous active-low reset clears counters and queue; memories need no clearing pass.
// A stall on the result side fills the queue and then raises in_stall.
`default_nettype none

module text_image_orientation_engine #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [1:0] in_action,
  input  wire  [7:0] in_char_code,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_char,
  output logic       out_row_end,
  output logic       out_image_end,
  output logic       out_picture_empty,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [2:0] cfg_orientation_mode
);

  tioe_pkg::cmd_t push_entry;
  tioe_pkg::cmd_t pop_entry;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  tioe_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_char_code         (in_char_code),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_orientation_mode (cfg_orientation_mode),
    .q_full               (full),
    .q_push               (push),
    .q_entry              (push_entry)
  );

  tioe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  tioe_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (empty),
    .q_entry           (pop_entry),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char          (out_char),
    .out_row_end       (out_row_end),
    .out_image_end     (out_image_end),
    .out_picture_empty (out_picture_empty)
  );

endmodule

`default_nettype wire

### sv/tioe_queue.sv
`default_nettype none
`include "text_image_orientation_engine_defines.svh"

module tioe_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  tioe_pkg::cmd_t  push_entry,
  output logic            full,
  input  wire             pop,
  output tioe_pkg::cmd_t  pop_entry,
  output logic            empty
);

  tioe_pkg::cmd_t                   slots_r [tioe_pkg::QUEUE_DEPTH];
  logic [tioe_pkg::QUEUE_AW-1:0]    wr_ptr_r;
  logic [tioe_pkg::QUEUE_AW-1:0]    rd_ptr_r;
  logic [tioe_pkg::QUEUE_AW:0]      count_r;
  logic [tioe_pkg::QUEUE_AW-1:0]    wr_ptr_nxt;
  logic [tioe_pkg::QUEUE_AW-1:0]    rd_ptr_nxt;
  logic [tioe_pkg::QUEUE_AW:0]      count_nxt;

  assign full      = (count_r == (tioe_pkg::QUEUE_AW+1)'(tioe_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  `TIOE_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= (tioe_pkg::QUEUE_AW+1)'(tioe_pkg::QUEUE_DEPTH), "queue count exceeds depth")
  `TIOE_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full, "push into a full queue")
  `TIOE_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !empty, "pop from an empty queue")

endmodule

`default_nettype wire

### sv/tioe_front.sv
`default_nettype none

module tioe_front #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  wire  [1:0]      in_action,
  input  wire  [7:0]      in_char_code,
  input  wire             cfg_valid,
  output logic            cfg_ready,
  input  wire  [2:0]      cfg_orientation_mode,
  input  wire             q_full,
  output logic            q_push,
  output tioe_pkg::cmd_t  q_entry
);

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RI = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CI = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PW = (RW > CW) ? RW : CW;

  logic [RW-1:0] height_r, height_nxt;
  logic [CW-1:0] width_r, width_nxt;
  logic [CW-1:0] load_col_r, load_col_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic [PW-1:0] row_pos_r, row_pos_nxt;
  logic [PW-1:0] col_pos_r, col_pos_nxt;

  logic          accept;
  logic          transpose;
  logic          pic_empty;
  logic [PW-1:0] rows, cols, r_cur, c_cur, c_inc, r_inc;
  logic [PW-1:0] si_full, sj_full;
  logic          last_col, last_row;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !q_full;

  assign transpose = (mode_r == tioe_pkg::MODE_TRANSPOSE);
  assign pic_empty = (height_r == '0) || (width_r == '0);
  assign rows      = transpose ? PW'(width_r) : PW'(height_r);
  assign cols      = transpose ? PW'(height_r) : PW'(width_r);

  always_comb begin
    if (row_pos_r >= rows || col_pos_r >= cols) begin
      r_cur = '0;
      c_cur = '0;
    end else begin
      r_cur = row_pos_r;
      c_cur = col_pos_r;
    end
    c_inc    = c_cur + 1'b1;
    r_inc    = r_cur + 1'b1;
    last_col = (c_cur == cols - 1'b1);
    last_row = (r_cur == rows - 1'b1);
    case (mode_r)
      tioe_pkg::MODE_VFLIP: begin
        si_full = PW'(height_r) - 1'b1 - r_cur;
        sj_full = c_cur;
      end
      tioe_pkg::MODE_HFLIP: begin
        si_full = r_cur;
        sj_full = PW'(width_r) - 1'b1 - c_cur;
      end
      tioe_pkg::MODE_ROTATE: begin
        si_full = PW'(height_r) - 1'b1 - r_cur;
        sj_full = PW'(width_r) - 1'b1 - c_cur;
      end
      tioe_pkg::MODE_TRANSPOSE: begin
        si_full = c_cur;
        sj_full = r_cur;
      end
      default: begin
        si_full = r_cur;
        sj_full = c_cur;
      end
    endcase
  end

  always_comb begin
    height_nxt   = height_r;
    width_nxt    = width_r;
    load_col_nxt = load_col_r;
    mode_nxt     = mode_r;
    row_pos_nxt  = row_pos_r;
    col_pos_nxt  = col_pos_r;
    q_push       = 1'b0;
    q_entry      = '0;
    q_entry.op   = tioe_pkg::OP_READ;

    if (cfg_valid) begin
      mode_nxt    = cfg_orientation_mode;
      row_pos_nxt = '0;
      col_pos_nxt = '0;
    end

    if (accept) begin
      case (in_action)
        tioe_pkg::ACT_STORE: begin
          row_pos_nxt = '0;
          col_pos_nxt = '0;
          if (height_r < RW'(MAX_ROWS) && load_col_r < CW'(MAX_COLS)) begin
            q_push       = 1'b1;
            q_entry.op   = tioe_pkg::OP_WRITE_CHAR;
            q_entry.row  = tioe_pkg::IDX_W'(height_r[RI-1:0]);
            q_entry.col  = tioe_pkg::IDX_W'(load_col_r[CI-1:0]);
            q_entry.data = in_char_code;
            load_col_nxt = load_col_r + 1'b1;
          end
        end
        tioe_pkg::ACT_EOL: begin
          row_pos_nxt  = '0;
          col_pos_nxt  = '0;
          load_col_nxt = '0;
          if (height_r < RW'(MAX_ROWS)) begin
            q_push       = 1'b1;
            q_entry.op   = tioe_pkg::OP_WRITE_LEN;
            q_entry.row  = tioe_pkg::IDX_W'(height_r[RI-1:0]);
            q_entry.data = 8'(load_col_r);
            height_nxt   = height_r + 1'b1;
            if (load_col_r > width_r) begin
              width_nxt = load_col_r;
            end
          end
        end
        tioe_pkg::ACT_CLEAR: begin
          height_nxt   = '0;
          width_nxt    = '0;
          load_col_nxt = '0;
          row_pos_nxt  = '0;
          col_pos_nxt  = '0;
        end
        tioe_pkg::ACT_FETCH: begin
          q_push     = 1'b1;
          q_entry.op = tioe_pkg::OP_READ;
          if (pic_empty) begin
            q_entry.empty = 1'b1;
          end else begin
            q_entry.row       = tioe_pkg::IDX_W'(si_full[RI-1:0]);
            q_entry.col       = tioe_pkg::IDX_W'(sj_full[CI-1:0]);
            q_entry.row_end   = last_col;
            q_entry.image_end = last_col && last_row;
            q_entry.invert    = (mode_r == tioe_pkg::MODE_INVERTED);
            if (c_inc >= cols) begin
              col_pos_nxt = '0;
              row_pos_nxt = (r_inc >= rows) ? '0 : r_inc;
            end else begin
              col_pos_nxt = c_inc;
              row_pos_nxt = r_cur;
            end
          end
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r   <= '0;
      width_r    <= '0;
      load_col_r <= '0;
      mode_r     <= tioe_pkg::MODE_ORIGINAL;
      row_pos_r  <= '0;
      col_pos_r  <= '0;
    end else begin
      height_r   <= height_nxt;
      width_r    <= width_nxt;
      load_col_r <= load_col_nxt;
      mode_r     <= mode_nxt;
      row_pos_r  <= row_pos_nxt;
      col_pos_r  <= col_pos_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/tioe_back.sv
`default_nettype none
`include "text_image_orientation_engine_defines.svh"

module tioe_back #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             q_empty,
  input  tioe_pkg::cmd_t  q_entry,
  output logic            q_pop,
  output logic            out_valid,
  input  wire             out_stall,
  output logic [7:0]      out_char,
  output logic            out_row_end,
  output logic            out_image_end,
  output logic            out_picture_empty
);

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RI    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CI    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    char_mem [DEPTH];
  logic [CW-1:0] len_mem  [MAX_ROWS];

  logic [RI-1:0] q_row;
  logic [CI-1:0] q_col;
  logic [AW-1:0] q_addr;

  logic          s1_valid_r;
  logic [CI-1:0] s1_col_r;
  logic          s1_row_end_r;
  logic          s1_image_end_r;
  logic          s1_empty_r;
  logic          s1_invert_r;
  logic [7:0]    rd_char_r;
  logic [CW-1:0] rd_len_r;

  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic          out_row_end_r;
  logic          out_image_end_r;
  logic          out_empty_r;

  logic          out_free;
  logic          s1_free;
  logic          s1_move;
  logic          read_pop;
  logic [7:0]    cell_char;
  logic [7:0]    mapped_char;

  assign q_row  = q_entry.row[RI-1:0];
  assign q_col  = q_entry.col[CI-1:0];
  assign q_addr = AW'(int'(q_row) * MAX_COLS + int'(q_col));

  assign out_free = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || out_free;
  assign s1_move  = s1_valid_r && out_free;
  assign q_pop    = !q_empty && s1_free;
  assign read_pop = q_pop && (q_entry.op == tioe_pkg::OP_READ);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      case (q_entry.op)
        tioe_pkg::OP_WRITE_CHAR: char_mem[q_addr] <= q_entry.data;
        tioe_pkg::OP_WRITE_LEN:  len_mem[q_row]   <= q_entry.data[CW-1:0];
        tioe_pkg::OP_READ: begin
          rd_char_r <= char_mem[q_addr];
          rd_len_r  <= len_mem[q_row];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cell_char = (CW'(s1_col_r) >= rd_len_r) ? tioe_pkg::CHAR_SPACE : rd_char_r;
    if (s1_empty_r) begin
      mapped_char = '0;
    end else if (s1_invert_r) begin
      mapped_char = (cell_char == tioe_pkg::CHAR_SPACE || cell_char == tioe_pkg::CHAR_AT)
                    ? tioe_pkg::CHAR_AT : 8'd0;
    end else begin
      mapped_char = cell_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= read_pop;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (read_pop) begin
      s1_col_r       <= q_col;
      s1_row_end_r   <= q_entry.row_end;
      s1_image_end_r <= q_entry.image_end;
      s1_empty_r     <= q_entry.empty;
      s1_invert_r    <= q_entry.invert;
    end
    if (s1_move) begin
      out_char_r      <= mapped_char;
      out_row_end_r   <= s1_row_end_r && !s1_empty_r;
      out_image_end_r <= s1_image_end_r && !s1_empty_r;
      out_empty_r     <= s1_empty_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char          = out_char_r;
  assign out_row_end       = out_row_end_r;
  assign out_image_end     = out_image_end_r;
  assign out_picture_empty = out_empty_r;

  `TIOE_ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid_r && out_empty_r, out_char_r == 8'd0 && !out_row_end_r && !out_image_end_r, "empty picture word carries nonzero fields")
  `TIOE_ASSERT_IMPLY(a_image_row_end, clk, rst_n, out_valid_r && out_image_end_r, out_row_end_r, "image end without row end")
  `TIOE_ASSERT_NEXT(a_read_enters, clk, rst_n, read_pop, s1_valid_r, "popped read lost before the output stage")

endmodule

`default_nettype wire
